>>> src/sensor_fault_screen_unit_macros.svh
// Assertion macros shared by the sensor fault screen RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef SENSOR_FAULT_SCREEN_UNIT_MACROS_SVH
`define SENSOR_FAULT_SCREEN_UNIT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define SFS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain condition checked at every rising edge outside reset.
`define SFS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

>>> src/sfs_pkg.sv
// Shared types, codes and constants for the sensor fault screen.
// No dependencies; imported by sfs_freeze_track and the top level.
package sfs_pkg;

    // Default number of channels for each sensor kind.
    localparam int CHANNELS_PER_KIND_DEF = 4;

    // Sensor kinds with per-channel state.
    localparam int KINDS = 4;

    // Field widths.
    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 16;
    localparam int BOUND_W  = 64;
    localparam int KIND_W   = 3;
    localparam int CHAN_W   = 2;

    // Reset value of the freeze limit register.
    localparam logic [COUNT_W-1:0] FREEZE_LIMIT_RST = 16'd100;

    // Check selected by the op bit.
    localparam logic OP_RANGE  = 1'b0;
    localparam logic OP_FREEZE = 1'b1;

    // Sensor kind codes.
    localparam logic [KIND_W-1:0] KIND_BARO  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MAG   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_IMU   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACCEL = 3'd3;

    // Reported fault codes.
    typedef enum logic [2:0] {
        FAULT_OK    = 3'd0,
        FAULT_BARO  = 3'd1,
        FAULT_MAG   = 3'd2,
        FAULT_IMU   = 3'd3,
        FAULT_ACCEL = 3'd4
    } fault_code_t;

    // Access strobes from the pipeline to the freeze tracker.
    typedef struct packed {
        logic lookup;
        logic update;
    } sfs_ctrl_t;

    // Fault code raised by a given sensor kind.
    function automatic fault_code_t fault_code_of(input logic [KIND_W-1:0] kind);
        fault_code_t code;
        case (kind)
            KIND_BARO:  code = FAULT_BARO;
            KIND_MAG:   code = FAULT_MAG;
            KIND_IMU:   code = FAULT_IMU;
            KIND_ACCEL: code = FAULT_ACCEL;
            default:    code = FAULT_OK;
        endcase
        return code;
    endfunction

endpackage

>>> src/sfs_freeze_track.sv
// Per-channel last sample and saturating repeat counter for the freeze check.
// Depends on sfs_pkg.
module sfs_freeze_track #(
    parameter int CHANNELS_PER_KIND = sfs_pkg::CHANNELS_PER_KIND_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [sfs_pkg::COUNT_W-1:0]          freeze_limit,
    input  sfs_pkg::sfs_ctrl_t                   ctrl,
    input  logic [$clog2(sfs_pkg::KINDS*CHANNELS_PER_KIND)-1:0] lookup_slot,
    input  logic [$clog2(sfs_pkg::KINDS*CHANNELS_PER_KIND)-1:0] update_slot,
    input  logic [sfs_pkg::SAMPLE_W-1:0]         sample,
    output logic                                 fault
);
    import sfs_pkg::*;

    localparam int SLOTS  = KINDS * CHANNELS_PER_KIND;
    localparam int WORD_W = COUNT_W + SAMPLE_W;

    logic [WORD_W-1:0] word_mem [SLOTS];
    logic [SLOTS-1:0]  slot_vld_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic              rd_vld_reg;
    logic              byp_reg;
    logic [WORD_W-1:0] byp_word_reg;

    logic [WORD_W-1:0]   cur_word;
    logic [SAMPLE_W-1:0] cur_sample;
    logic [COUNT_W-1:0]  cur_count;
    logic [COUNT_W-1:0]  count_inc;
    logic [COUNT_W-1:0]  count_new;
    logic [WORD_W-1:0]   wr_word;
    logic                same;
    logic                bypass;

    // Entry of the item now held: a same-cycle write is forwarded, an unwritten
    // slot reads as zero.
    always_comb
    begin
        if (byp_reg)
        begin
            cur_word = byp_word_reg;
        end
        else if (rd_vld_reg)
        begin
            cur_word = rd_word_reg;
        end
        else
        begin
            cur_word = '0;
        end
    end

    assign cur_sample = cur_word[SAMPLE_W-1:0];
    assign cur_count  = cur_word[WORD_W-1:SAMPLE_W];

    // Repeat counting with saturation; a new value clears the count.
    assign same      = (sample == cur_sample);
    assign count_inc = (cur_count == '1) ? cur_count : cur_count + 16'd1;
    assign count_new = same ? count_inc : '0;
    assign fault     = same && (count_inc > freeze_limit);
    assign wr_word   = {count_new, sample};

    assign bypass = ctrl.lookup && ctrl.update && (lookup_slot == update_slot);

    // Written flags for each slot, and the read-valid and bypass flags of the lookup.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            if (ctrl.update)
            begin
                slot_vld_reg[update_slot] <= 1'b1;
            end
            if (ctrl.lookup)
            begin
                rd_vld_reg <= slot_vld_reg[lookup_slot];
                byp_reg    <= bypass;
            end
        end
    end

    // Sample and count store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            word_mem[update_slot] <= wr_word;
        end
        if (ctrl.lookup)
        begin
            rd_word_reg  <= word_mem[lookup_slot];
            byp_word_reg <= wr_word;
        end
    end

endmodule

>>> src/sensor_fault_screen_unit.sv
// Sensor fault screen: range and freeze checks with sticky per-channel flags.
// An input moves through the first stage, second stage and output register to the output.
// Throughput is one item per cycle while the result stream is not stalled, set by the
// multiplier stage feeding the range compare and by the update of the per-channel store.
// Reset clears the pipeline, the fault flags, the per-channel store and sets
// the freeze limit to 100; the block takes items straight after reset.
`include "sensor_fault_screen_unit_macros.svh"

module sensor_fault_screen_unit #(
    parameter int CHANNELS_PER_KIND = sfs_pkg::CHANNELS_PER_KIND_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Input stream.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata from bit 0: channel[1:0], sample[33:2], scale_factor[65:34],
    // upper_bound[129:66], lower_bound[193:130], zero fill [199:194]
    input  logic [199:0]                s_axis_tdata,
    // tuser from bit 0: op[0], sensor_kind[3:1]
    input  logic [3:0]                  s_axis_tuser,
    // Result stream.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tdata from bit 0: fault_code[2:0], fault_channel[4:3],
    // channel_faulty[5], zero fill [7:6]
    output logic [7:0]                  m_axis_tdata,
    // Freeze limit register.
    input  logic                        cfg_wr_en,
    input  logic [sfs_pkg::COUNT_W-1:0] cfg_wr_data
);
    import sfs_pkg::*;

    localparam int SLOTS  = KINDS * CHANNELS_PER_KIND;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [KIND_W-1:0] KIND_LIMIT = KIND_W'(KINDS);

    // Input field unpacking.
    logic                       in_op;
    logic [KIND_W-1:0]          in_kind;
    logic [CHAN_W-1:0]          in_chan;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic signed [SAMPLE_W-1:0] in_scale;
    logic signed [BOUND_W-1:0]  in_ub;
    logic signed [BOUND_W-1:0]  in_lb;
    logic                       in_ok;
    logic [SLOT_W-1:0]          in_slot;

    assign in_op     = s_axis_tuser[0];
    assign in_kind   = s_axis_tuser[3:1];
    assign in_chan   = s_axis_tdata[1:0];
    assign in_sample = s_axis_tdata[33:2];
    assign in_scale  = s_axis_tdata[65:34];
    assign in_ub     = s_axis_tdata[129:66];
    assign in_lb     = s_axis_tdata[193:130];

    // Slot of a known kind and an existing channel.
    assign in_ok   = (in_kind < KIND_LIMIT) && (32'(in_chan) < CHANNELS_PER_KIND);
    assign in_slot = SLOT_W'(in_kind[1:0]) * SLOT_W'(CHANNELS_PER_KIND)
                     + SLOT_W'(in_chan);

    // Pipeline registers.
    logic                       freeze_limit_reg;
    logic [COUNT_W-1:0]         limit_reg;

    logic                       r1_vld_reg;
    logic                       r1_op_reg;
    logic [KIND_W-1:0]          r1_kind_reg;
    logic [CHAN_W-1:0]          r1_chan_reg;
    logic                       r1_ok_reg;
    logic [SLOT_W-1:0]          r1_slot_reg;
    logic signed [SAMPLE_W-1:0] r1_sample_reg;
    logic signed [SAMPLE_W-1:0] r1_scale_reg;
    logic signed [BOUND_W-1:0]  r1_ub_reg;
    logic signed [BOUND_W-1:0]  r1_lb_reg;

    logic                       r2_vld_reg;
    logic                       r2_op_reg;
    logic [KIND_W-1:0]          r2_kind_reg;
    logic [CHAN_W-1:0]          r2_chan_reg;
    logic                       r2_ok_reg;
    logic [SLOT_W-1:0]          r2_slot_reg;
    logic signed [BOUND_W-1:0]  r2_prod_reg;
    logic signed [BOUND_W-1:0]  r2_ub_reg;
    logic signed [BOUND_W-1:0]  r2_lb_reg;
    logic                       r2_frz_reg;

    logic                       out_vld_reg;
    fault_code_t                out_code_reg;
    logic [CHAN_W-1:0]          out_chan_reg;
    logic                       out_faulty_reg;

    logic [SLOTS-1:0]           flag_reg;

    // Stage advance: each stage moves on when the next one is empty or moving.
    logic in_load;
    logic r2_load;
    logic out_load;

    assign out_load      = r2_vld_reg && (!out_vld_reg || m_axis_tready);
    assign r2_load       = r1_vld_reg && (!r2_vld_reg || out_load);
    assign s_axis_tready = !r1_vld_reg || r2_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    // Freeze check on the item held in the first stage.
    sfs_ctrl_t          frz_ctrl;
    logic               frz_fault;

    assign frz_ctrl.lookup = in_load && in_ok;
    assign frz_ctrl.update = r2_load && r1_ok_reg && (r1_op_reg == OP_FREEZE);

    sfs_freeze_track #(
        .CHANNELS_PER_KIND (CHANNELS_PER_KIND)
    ) u_freeze (
        .clk          (clk),
        .rst_n        (rst_n),
        .freeze_limit (limit_reg),
        .ctrl         (frz_ctrl),
        .lookup_slot  (in_slot),
        .update_slot  (r1_slot_reg),
        .sample       (r1_sample_reg),
        .fault        (frz_fault)
    );

    // Exact Q.24 product of sample and conversion factor.
    logic signed [BOUND_W-1:0] prod;

    assign prod = BOUND_W'(r1_sample_reg) * BOUND_W'(r1_scale_reg);

    // Fault decision and sticky flag for the item in the second stage.
    logic range_fault;
    logic fault;
    logic faulty;

    assign range_fault = (r2_prod_reg > r2_ub_reg) || (r2_prod_reg < r2_lb_reg);
    assign fault       = r2_ok_reg && ((r2_op_reg == OP_RANGE) ? range_fault : r2_frz_reg);
    assign faulty      = r2_ok_reg && (flag_reg[r2_slot_reg] || fault);

    // Control state: valids, flags and the freeze limit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_vld_reg       <= 1'b0;
            r2_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
            flag_reg         <= '0;
            limit_reg        <= FREEZE_LIMIT_RST;
            freeze_limit_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            freeze_limit_reg <= cfg_wr_en;
            if (s_axis_tready)
            begin
                r1_vld_reg <= s_axis_tvalid;
            end
            if (!r2_vld_reg || out_load)
            begin
                r2_vld_reg <= r1_vld_reg;
            end
            if (!out_vld_reg || m_axis_tready)
            begin
                out_vld_reg <= r2_vld_reg;
            end
            if (out_load && fault)
            begin
                flag_reg[r2_slot_reg] <= 1'b1;
            end
        end
    end

    // Payload of the pipeline stages.
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            r1_op_reg     <= in_op;
            r1_kind_reg   <= in_kind;
            r1_chan_reg   <= in_chan;
            r1_ok_reg     <= in_ok;
            r1_slot_reg   <= in_slot;
            r1_sample_reg <= in_sample;
            r1_scale_reg  <= in_scale;
            r1_ub_reg     <= in_ub;
            r1_lb_reg     <= in_lb;
        end
        if (r2_load)
        begin
            r2_op_reg   <= r1_op_reg;
            r2_kind_reg <= r1_kind_reg;
            r2_chan_reg <= r1_chan_reg;
            r2_ok_reg   <= r1_ok_reg;
            r2_slot_reg <= r1_slot_reg;
            r2_prod_reg <= prod;
            r2_ub_reg   <= r1_ub_reg;
            r2_lb_reg   <= r1_lb_reg;
            r2_frz_reg  <= frz_fault;
        end
        if (out_load)
        begin
            out_code_reg   <= fault ? fault_code_of(r2_kind_reg) : FAULT_OK;
            out_chan_reg   <= fault ? r2_chan_reg : '0;
            out_faulty_reg <= faulty;
        end
    end

    // Result stream.
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {2'b00, out_faulty_reg, out_chan_reg, out_code_reg};

    // A reported fault always leaves the addressed channel flagged.
    `SFS_ASSERT_IMP(a_fault_sets_flag, m_axis_tvalid && (out_code_reg != FAULT_OK),
                    out_faulty_reg, "fault reported without sticky flag")
    // With no fault the reported channel is zero.
    `SFS_ASSERT_IMP(a_ok_chan_zero, m_axis_tvalid && (out_code_reg == FAULT_OK),
                    out_chan_reg == '0, "fault channel set on an ok result")
    // Input is held off only while the first stage holds an item.
    `SFS_ASSERT_ALWAYS(a_ready_stage, s_axis_tready || r1_vld_reg,
                       "input stalled with an empty first stage")
    // A freeze limit write lands in the register.
    `SFS_ASSERT_IMP(a_limit_write, freeze_limit_reg, limit_reg == $past(cfg_wr_data),
                    "freeze limit write lost")

endmodule
